// File: design/slfr_pkg.sv
// ----------------------------------------------------------------------------
// slfr_pkg
// shared types, constants and the crc-8 byte update for the frame receiver
// ----------------------------------------------------------------------------
`default_nettype none

package slfr_pkg;

    localparam int unsigned MAX_PAYLOAD_DEF = 64;

    localparam logic [7:0] SYNC_BYTE  = 8'h55;
    localparam logic [7:0] CRC_POLY   = 8'h07;
    localparam logic [7:0] CRC_MSB    = 8'h80;
    localparam logic [7:0] BCAST_SLOT = 8'hFF;

    typedef enum logic [2:0] {
        PH_SYNC  = 3'd0,
        PH_TYPE  = 3'd1,
        PH_SLOT  = 3'd2,
        PH_LEN   = 3'd3,
        PH_DATA  = 3'd4,
        PH_CHECK = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_END   = 2'd1,
        KIND_ABORT = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] frame_type;
        logic [7:0] slot_field;
        logic [7:0] payload_length;
        logic [5:0] byte_index;
        logic [7:0] data_byte;
        logic       crc_ok;
        logic       addressed;
        logic       last;
    } t_result;

    // msb-first crc-8, no reflection, no final xor
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] din);
        logic [7:0] v;
        v = crc ^ din;
        for (int k = 0; k < 8; k++) begin
            if ((v & CRC_MSB) != 8'h00) begin
                v = {v[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                v = {v[6:0], 1'b0};
            end
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// File: design/slfr_in_stage.sv
// ----------------------------------------------------------------------------
// slfr_in_stage
// input register for received bytes, refilled in the cycle it is drained
// ----------------------------------------------------------------------------
`default_nettype none

module slfr_in_stage (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_take,
    output logic            o_stall,
    output logic            o_valid,
    output logic [7:0]      o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       in_ready;
    logic       n_valid;

    assign in_ready = i_rst_n && (!r_valid || i_take);
    assign o_stall  = !in_ready;
    assign o_valid  = r_valid;
    assign o_byte   = r_byte;

    always_comb begin
        n_valid = r_valid;
        if (i_valid && in_ready) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && in_ready) begin
            r_byte <= i_byte;
        end
    end

endmodule

`default_nettype wire

// File: design/slfr_parse.sv
// ----------------------------------------------------------------------------
// slfr_parse
// frame parser: sync hunt, header capture, payload count and crc-8 check
// ----------------------------------------------------------------------------
`default_nettype none

module slfr_parse #(
    parameter int unsigned MAX_PAYLOAD = slfr_pkg::MAX_PAYLOAD_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_fire,
    input  wire logic [7:0]  i_byte,
    input  wire logic [7:0]  i_own_slot,
    output logic             o_res_valid,
    output slfr_pkg::t_result o_res
);

    localparam int unsigned CW = $clog2(MAX_PAYLOAD + 1);

    slfr_pkg::t_phase r_phase, n_phase;
    logic [7:0]       r_type, n_type;
    logic [7:0]       r_slot, n_slot;
    logic [7:0]       r_len, n_len;
    logic [CW-1:0]    r_count, n_count;
    logic [7:0]       r_crc, n_crc;
    logic [CW-1:0]    count_inc;
    logic [7:0]       crc_next;

    assign count_inc = r_count + CW'(1);
    assign crc_next  = slfr_pkg::crc8_byte(r_crc, i_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= slfr_pkg::PH_SYNC;
            r_type  <= '0;
            r_slot  <= '0;
            r_len   <= '0;
            r_count <= '0;
            r_crc   <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_type  <= n_type;
            r_slot  <= n_slot;
            r_len   <= n_len;
            r_count <= n_count;
            r_crc   <= n_crc;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_type  = r_type;
        n_slot  = r_slot;
        n_len   = r_len;
        n_count = r_count;
        n_crc   = r_crc;

        o_res_valid          = 1'b0;
        o_res.kind           = slfr_pkg::KIND_DATA;
        o_res.frame_type     = r_type;
        o_res.slot_field     = r_slot;
        o_res.payload_length = r_len;
        o_res.byte_index     = '0;
        o_res.data_byte      = '0;
        o_res.crc_ok         = 1'b0;
        o_res.addressed      = (r_slot == i_own_slot) || (r_slot == slfr_pkg::BCAST_SLOT);
        o_res.last           = 1'b0;

        case (r_phase)
            slfr_pkg::PH_TYPE: begin
                n_type  = i_byte;
                n_crc   = slfr_pkg::crc8_byte(8'h00, i_byte);
                n_phase = slfr_pkg::PH_SLOT;
            end
            slfr_pkg::PH_SLOT: begin
                n_slot  = i_byte;
                n_crc   = crc_next;
                n_phase = slfr_pkg::PH_LEN;
            end
            slfr_pkg::PH_LEN: begin
                n_len   = i_byte;
                n_crc   = crc_next;
                n_count = '0;
                n_phase = (i_byte != 8'h00) ? slfr_pkg::PH_DATA : slfr_pkg::PH_CHECK;
            end
            slfr_pkg::PH_DATA: begin
                n_crc       = crc_next;
                n_count     = count_inc;
                o_res_valid = i_fire;
                if (count_inc >= CW'(MAX_PAYLOAD)) begin
                    n_phase    = slfr_pkg::PH_SYNC;
                    o_res.kind = slfr_pkg::KIND_ABORT;
                    o_res.last = 1'b1;
                end else begin
                    if (9'(count_inc) >= {1'b0, r_len}) begin
                        n_phase = slfr_pkg::PH_CHECK;
                    end
                    o_res.byte_index = 6'(r_count);
                    o_res.data_byte  = i_byte;
                end
            end
            slfr_pkg::PH_CHECK: begin
                n_phase      = slfr_pkg::PH_SYNC;
                o_res_valid  = i_fire;
                o_res.kind   = slfr_pkg::KIND_END;
                o_res.crc_ok = (i_byte == r_crc);
                o_res.last   = 1'b1;
            end
            default: begin
                n_phase = (i_byte == slfr_pkg::SYNC_BYTE) ? slfr_pkg::PH_TYPE
                                                          : slfr_pkg::PH_SYNC;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: design/slfr_out_stage.sv
// ----------------------------------------------------------------------------
// slfr_out_stage
// result register, holds a word while the consumer stalls
// ----------------------------------------------------------------------------
`default_nettype none

module slfr_out_stage (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire slfr_pkg::t_result i_res,
    input  wire logic              i_stall,
    output logic                   o_ready,
    output logic                   o_valid,
    output slfr_pkg::t_result      o_res
);

    logic              r_valid;
    slfr_pkg::t_result r_res;

    assign o_ready = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_load) begin
            r_res <= i_res;
        end
    end

endmodule

`default_nettype wire

// File: design/sync_len_frame_receiver_crc8.sv
// ----------------------------------------------------------------------------
// sync_len_frame_receiver_crc8
// serial frame receiver: sync 0x55, type, slot, length, payload, crc-8 check
//
//   channel   direction  handshake                  payload
//   rx        in         i_rx_valid / o_rx_stall    i_rx_byte
//   result    out        o_res_valid / i_res_stall  o_kind .. o_last
//   config    in         i_cfg_we                   i_cfg_data (own slot)
//
// one word per cycle sustained while no result stall backs up; a word is parsed
// between the input register and the result register, so its result is
// registered in the result register once the parser takes the word
// header and sync words give no result; payload, end and abort give one
// synchronous active-low reset returns the parser to sync hunting
// a result stall holds the result register and backs up into o_rx_stall
// ----------------------------------------------------------------------------
`default_nettype none

module sync_len_frame_receiver_crc8 #(
    parameter int unsigned MAX_PAYLOAD = slfr_pkg::MAX_PAYLOAD_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [7:0] i_cfg_data,
    input  wire logic       i_rx_valid,
    output logic            o_rx_stall,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_res_valid,
    input  wire logic       i_res_stall,
    output logic [1:0]      o_kind,
    output logic [7:0]      o_frame_type,
    output logic [7:0]      o_slot_field,
    output logic [7:0]      o_payload_length,
    output logic [5:0]      o_byte_index,
    output logic [7:0]      o_data_byte,
    output logic            o_crc_ok,
    output logic            o_addressed,
    output logic            o_last
);

    logic [7:0]        r_own_slot;
    logic              in_valid;
    logic [7:0]        in_byte;
    logic              out_ready;
    logic              fire;
    logic              res_valid;
    slfr_pkg::t_result res;
    slfr_pkg::t_result out_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_slot <= '0;
        end else if (i_cfg_we) begin
            r_own_slot <= i_cfg_data;
        end
    end

    assign fire = in_valid && out_ready;

    slfr_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_rx_valid),
        .i_byte  (i_rx_byte),
        .i_take  (fire),
        .o_stall (o_rx_stall),
        .o_valid (in_valid),
        .o_byte  (in_byte)
    );

    slfr_parse #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_byte      (in_byte),
        .i_own_slot  (r_own_slot),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    slfr_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_valid),
        .i_res   (res),
        .i_stall (i_res_stall),
        .o_ready (out_ready),
        .o_valid (o_res_valid),
        .o_res   (out_res)
    );

    assign o_kind           = out_res.kind;
    assign o_frame_type     = out_res.frame_type;
    assign o_slot_field     = out_res.slot_field;
    assign o_payload_length = out_res.payload_length;
    assign o_byte_index     = out_res.byte_index;
    assign o_data_byte      = out_res.data_byte;
    assign o_crc_ok         = out_res.crc_ok;
    assign o_addressed      = out_res.addressed;
    assign o_last           = out_res.last;

endmodule

`default_nettype wire

// File: design/slfr_checker.sv
// ----------------------------------------------------------------------------
// slfr_checker
// port-level checks on the frame receiver result stream
// ----------------------------------------------------------------------------
`default_nettype none

module slfr_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_res_valid,
    input wire logic       i_res_stall,
    input wire logic [1:0] o_kind,
    input wire logic [5:0] o_byte_index,
    input wire logic [7:0] o_data_byte,
    input wire logic       o_crc_ok,
    input wire logic       o_last
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res_valid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && i_res_stall |=> o_res_valid && $stable(o_kind) && $stable(o_data_byte))
        else $error("stalled result changed");

    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_last == (o_kind != slfr_pkg::KIND_DATA)))
        else $error("last does not match kind");

    a_nondata_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_kind != slfr_pkg::KIND_DATA |-> o_byte_index == 6'd0
            && o_data_byte == 8'd0)
        else $error("end or abort carries payload fields");

    a_crc_only_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_crc_ok |-> o_kind == slfr_pkg::KIND_END)
        else $error("crc ok outside frame end");

endmodule

bind sync_len_frame_receiver_crc8 slfr_checker u_slfr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_res_valid  (o_res_valid),
    .i_res_stall  (i_res_stall),
    .o_kind       (o_kind),
    .o_byte_index (o_byte_index),
    .o_data_byte  (o_data_byte),
    .o_crc_ok     (o_crc_ok),
    .o_last       (o_last)
);

`default_nettype wire

// File: bench/sync_len_frame_receiver_crc8_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_len_frame_receiver_crc8_tb
// feeds serial words into the frame receiver and checks every result word
//
// a scoreboard class tracks the parser state, header fields, payload count and
// running crc-8 of the received words and queues the expected result words;
// results are compared field by field in arrival order. a short directed part
// is followed by random frames, truncated frames and line noise over several
// own-slot settings, with random idling on the input and stalls on the output
// ----------------------------------------------------------------------------

class frame_scoreboard;
    logic [7:0]       own_slot;
    slfr_pkg::t_phase phase;
    logic [7:0]       hdr_type;
    logic [7:0]       hdr_slot;
    logic [7:0]       hdr_len;
    logic [7:0]       crc;
    int               pay_count;
    int               errors;
    slfr_pkg::t_result expected_q[$];

    function new();
        own_slot  = 8'h00;
        phase     = slfr_pkg::PH_SYNC;
        hdr_type  = 8'h00;
        hdr_slot  = 8'h00;
        hdr_len   = 8'h00;
        crc       = 8'h00;
        pay_count = 0;
        errors    = 0;
    endfunction

    // bit-serial msb-first crc-8
    static function logic [7:0] crc_next(logic [7:0] c, logic [7:0] b);
        logic fb;
        for (int i = 7; i >= 0; i--) begin
            fb = c[7] ^ b[i];
            c  = {c[6:0], 1'b0} ^ (fb ? slfr_pkg::CRC_POLY : 8'h00);
        end
        return c;
    endfunction

    function void push_result(slfr_pkg::t_kind k, logic [5:0] idx, logic [7:0] d,
                              logic ok, logic lst);
        slfr_pkg::t_result r;
        r.kind           = k;
        r.frame_type     = hdr_type;
        r.slot_field     = hdr_slot;
        r.payload_length = hdr_len;
        r.byte_index     = idx;
        r.data_byte      = d;
        r.crc_ok         = ok;
        r.addressed      = (hdr_slot == own_slot) || (hdr_slot == slfr_pkg::BCAST_SLOT);
        r.last           = lst;
        expected_q.push_back(r);
    endfunction

    function void take_byte(logic [7:0] b);
        int idx;
        case (phase)
            slfr_pkg::PH_TYPE: begin
                hdr_type = b;
                crc      = crc_next(8'h00, b);
                phase    = slfr_pkg::PH_SLOT;
            end
            slfr_pkg::PH_SLOT: begin
                hdr_slot = b;
                crc      = crc_next(crc, b);
                phase    = slfr_pkg::PH_LEN;
            end
            slfr_pkg::PH_LEN: begin
                hdr_len   = b;
                crc       = crc_next(crc, b);
                pay_count = 0;
                phase     = (b != 8'h00) ? slfr_pkg::PH_DATA : slfr_pkg::PH_CHECK;
            end
            slfr_pkg::PH_DATA: begin
                idx       = pay_count;
                crc       = crc_next(crc, b);
                pay_count = pay_count + 1;
                if (pay_count >= slfr_pkg::MAX_PAYLOAD_DEF) begin
                    // overflow wins over reaching the length
                    phase = slfr_pkg::PH_SYNC;
                    push_result(slfr_pkg::KIND_ABORT, 6'd0, 8'h00, 1'b0, 1'b1);
                end else begin
                    if (pay_count >= hdr_len) begin
                        phase = slfr_pkg::PH_CHECK;
                    end
                    push_result(slfr_pkg::KIND_DATA, idx[5:0], b, 1'b0, 1'b0);
                end
            end
            slfr_pkg::PH_CHECK: begin
                phase = slfr_pkg::PH_SYNC;
                push_result(slfr_pkg::KIND_END, 6'd0, 8'h00, b == crc, 1'b1);
            end
            default: begin
                phase = (b == slfr_pkg::SYNC_BYTE) ? slfr_pkg::PH_TYPE : slfr_pkg::PH_SYNC;
            end
        endcase
    endfunction

    function void compare(string name, logic [7:0] e, logic [7:0] a);
        if (a !== e) begin
            $display("%0t %s: expected %0h, got %0h", $time, name, e, a);
            errors++;
        end
    endfunction

    function void check_result(logic [1:0] kind, logic [7:0] ftype, logic [7:0] slot,
                               logic [7:0] len, logic [5:0] idx, logic [7:0] d,
                               logic ok, logic addr, logic lst);
        slfr_pkg::t_result e;
        if (expected_q.size() == 0) begin
            $display("%0t result word with nothing expected: kind %0h idx %0h data %0h",
                     $time, kind, idx, d);
            errors++;
            return;
        end
        e = expected_q.pop_front();
        compare("kind", {6'd0, e.kind}, {6'd0, kind});
        compare("frame_type", e.frame_type, ftype);
        compare("slot_field", e.slot_field, slot);
        compare("payload_length", e.payload_length, len);
        compare("byte_index", {2'd0, e.byte_index}, {2'd0, idx});
        compare("data_byte", e.data_byte, d);
        compare("crc_ok", {7'd0, e.crc_ok}, {7'd0, ok});
        compare("addressed", {7'd0, e.addressed}, {7'd0, addr});
        compare("last", {7'd0, e.last}, {7'd0, lst});
    endfunction

    function int pending();
        return expected_q.size();
    endfunction
endclass

module sync_len_frame_receiver_crc8_tb;

    localparam int MAX_PAY     = slfr_pkg::MAX_PAYLOAD_DEF;
    localparam int CYCLE_LIMIT = 300000;
    localparam int PHASE_ITEMS = 340;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [7:0] i_cfg_data = 8'h00;
    logic       i_rx_valid = 1'b0;
    logic [7:0] i_rx_byte = 8'h00;
    logic       i_res_stall = 1'b0;
    logic       o_rx_stall;
    logic       o_res_valid;
    logic [1:0] o_kind;
    logic [7:0] o_frame_type;
    logic [7:0] o_slot_field;
    logic [7:0] o_payload_length;
    logic [5:0] o_byte_index;
    logic [7:0] o_data_byte;
    logic       o_crc_ok;
    logic       o_addressed;
    logic       o_last;

    frame_scoreboard sb;
    bit              calm = 1'b0;
    int              frame_items = 0;
    int              cycle_count = 0;
    logic [7:0]      payload_q[$];

    sync_len_frame_receiver_crc8 u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_rx_valid       (i_rx_valid),
        .o_rx_stall       (o_rx_stall),
        .i_rx_byte        (i_rx_byte),
        .o_res_valid      (o_res_valid),
        .i_res_stall      (i_res_stall),
        .o_kind           (o_kind),
        .o_frame_type     (o_frame_type),
        .o_slot_field     (o_slot_field),
        .o_payload_length (o_payload_length),
        .o_byte_index     (o_byte_index),
        .o_data_byte      (o_data_byte),
        .o_crc_ok         (o_crc_ok),
        .o_addressed      (o_addressed),
        .o_last           (o_last)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_res_stall <= i_rst_n && !calm && ($urandom_range(0, 99) < 28);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_rx_valid && !o_rx_stall) begin
            sb.take_byte(i_rx_byte);
        end
        if (i_rst_n && o_res_valid && !i_res_stall) begin
            sb.check_result(o_kind, o_frame_type, o_slot_field, o_payload_length,
                            o_byte_index, o_data_byte, o_crc_ok, o_addressed, o_last);
        end
    end

    // entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b);
        while (!calm && $urandom_range(0, 99) < 28) begin
            i_rx_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (o_rx_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drive_frame(input logic [7:0] ftype, input logic [7:0] slot,
                               input logic [7:0] len, input bit good, input int cut);
        logic [7:0] seq[$];
        logic [7:0] c;
        int         npay;
        int         n;
        npay = (len < MAX_PAY) ? len : MAX_PAY;
        while (payload_q.size() < npay) payload_q.push_back(8'($urandom_range(0, 255)));
        seq.push_back(slfr_pkg::SYNC_BYTE);
        seq.push_back(ftype);
        seq.push_back(slot);
        seq.push_back(len);
        c = sb.crc_next(8'h00, ftype);
        c = sb.crc_next(c, slot);
        c = sb.crc_next(c, len);
        for (int i = 0; i < npay; i++) begin
            seq.push_back(payload_q[i]);
            c = sb.crc_next(c, payload_q[i]);
        end
        if (len < MAX_PAY) begin
            seq.push_back(good ? c : c ^ 8'($urandom_range(1, 255)));
        end
        payload_q.delete();
        n = (cut < 0 || cut > seq.size()) ? seq.size() : cut;
        for (int i = 0; i < n; i++) send_byte(seq[i]);
        frame_items += n;
    endtask

    task automatic random_frame();
        int         r;
        logic [7:0] len;
        logic [7:0] slot;
        int         cut;
        r = $urandom_range(0, 99);
        if (r < 55)      len = 8'($urandom_range(0, 8));
        else if (r < 80) len = 8'($urandom_range(9, 40));
        else if (r < 93) len = 8'($urandom_range(41, MAX_PAY - 1));
        else if (r < 97) len = 8'(MAX_PAY);
        else             len = 8'($urandom_range(MAX_PAY + 1, 255));
        r = $urandom_range(0, 99);
        if (r < 35)      slot = sb.own_slot;
        else if (r < 55) slot = slfr_pkg::BCAST_SLOT;
        else             slot = 8'($urandom_range(0, 255));
        // some frames are cut short and run into the next one
        cut = ($urandom_range(0, 99) < 8) ? $urandom_range(1, 4 + len) : -1;
        drive_frame(8'($urandom_range(0, 255)), slot, len, $urandom_range(0, 99) < 75, cut);
    endtask

    task automatic drain();
        i_rx_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic write_own_slot(input logic [7:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.own_slot = v;
    endtask

    initial begin
        logic [7:0] slot_plan[5];
        int         target;
        sb = new();
        slot_plan[0] = 8'h00;
        slot_plan[1] = 8'hFF;
        slot_plan[2] = 8'($urandom_range(1, 254));
        slot_plan[3] = 8'($urandom_range(1, 254));
        slot_plan[4] = 8'h00;

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        write_own_slot(8'h3C);
        // noise while hunting for sync
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h54);
        // empty frame for this board
        drive_frame(8'h00, 8'h3C, 8'h00, 1'b1, -1);
        // broadcast, wrong check
        payload_q.push_back(8'hFF);
        payload_q.push_back(8'h00);
        drive_frame(8'hFF, slfr_pkg::BCAST_SLOT, 8'h02, 1'b0, -1);
        // payload equal to the sync word, other slot
        payload_q.push_back(slfr_pkg::SYNC_BYTE);
        drive_frame(8'hA5, 8'h00, 8'h01, 1'b1, -1);
        // type equal to the sync word, wrong check
        drive_frame(slfr_pkg::SYNC_BYTE, 8'h12, 8'h00, 1'b0, -1);
        drain();

        target = frame_items;
        for (int ph = 0; ph < 5; ph++) begin
            write_own_slot(slot_plan[ph]);
            calm = (ph == 2);
            target += PHASE_ITEMS;
            if (ph == 0) begin
                // overflow exactly at the length, and past it
                drive_frame(8'($urandom_range(0, 255)), sb.own_slot, 8'(MAX_PAY), 1'b1, -1);
                drive_frame(8'($urandom_range(0, 255)), 8'hFF, 8'd255, 1'b1, -1);
            end
            while (frame_items < target) begin
                if ($urandom_range(0, 99) < 10) begin
                    repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
                end else begin
                    random_frame();
                end
            end
            drain();
        end
        calm = 1'b0;

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
